>>> design/ean13_pkg.sv
// Shared types, symbol tables and lookup helpers for the EAN-13 decoder.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package ean13_pkg;

  localparam int unsigned NumModules = 95;
  localparam int unsigned NumSide    = 6;
  localparam int unsigned NumDigits  = 13;
  localparam int unsigned DigitsW    = 4 * NumDigits;

  typedef enum logic [1:0] {
    ST_FWD  = 2'd0,
    ST_REV  = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  // Left-hand odd (A), left-hand even (B) and right-hand symbol patterns,
  // first module in the msb.
  localparam logic [9:0][6:0] TabL = '{
    7'h0B, 7'h37, 7'h3B, 7'h2F, 7'h31, 7'h23, 7'h3D, 7'h13, 7'h19, 7'h0D};
  localparam logic [9:0][6:0] TabG = '{
    7'h17, 7'h09, 7'h11, 7'h05, 7'h39, 7'h1D, 7'h21, 7'h1B, 7'h33, 7'h27};
  localparam logic [9:0][6:0] TabR = '{
    7'h74, 7'h48, 7'h44, 7'h50, 7'h4E, 7'h5C, 7'h42, 7'h6C, 7'h66, 7'h72};
  // Parity pattern of the six left symbols (1 = B) for each leading digit
  localparam logic [9:0][5:0] TabPar = '{
    6'h1A, 6'h16, 6'h15, 6'h1C, 6'h19, 6'h13, 6'h0E, 6'h0D, 6'h0B, 6'h00};

  typedef struct packed {
    logic       hit;
    logic       even;
    logic [3:0] dig;
  } left_hit_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] dig;
  } dig_hit_t;

  // Per-direction result of the symbol lookups; dig[i] is digit i+1.
  typedef struct packed {
    logic [11:0][3:0] dig;
    logic [5:0]       par;
    logic             ok;
  } dir_sym_t;

  typedef struct packed {
    dir_sym_t [1:0] dir;
    logic           guards_ok;
  } sym_res_t;

  // Per-direction digits with leading digit resolved and the weighted sum
  typedef struct packed {
    logic [DigitsW-1:0] bcd;
    logic [7:0]         sum;
    logic               ok;
  } dir_sum_t;

  typedef struct packed {
    dir_sum_t [1:0] dir;
    logic           guards_ok;
  } sum_res_t;

  function automatic left_hit_t decode_left(input logic [6:0] p);
    left_hit_t r;
    r = '0;
    for (int k = 0; k < 10; k++) begin
      if (!r.hit) begin
        if (TabL[k] == p) begin
          r.hit = 1'b1;
          r.even = 1'b0;
          r.dig = 4'(k);
        end else if (TabG[k] == p) begin
          r.hit = 1'b1;
          r.even = 1'b1;
          r.dig = 4'(k);
        end
      end
    end
    return r;
  endfunction

  function automatic dig_hit_t decode_right(input logic [6:0] p);
    dig_hit_t r;
    r = '0;
    for (int k = 0; k < 10; k++) begin
      if (!r.hit && TabR[k] == p) begin
        r.hit = 1'b1;
        r.dig = 4'(k);
      end
    end
    return r;
  endfunction

  function automatic dig_hit_t decode_lead(input logic [5:0] par);
    dig_hit_t r;
    r = '0;
    for (int k = 0; k < 10; k++) begin
      if (!r.hit && TabPar[k] == par) begin
        r.hit = 1'b1;
        r.dig = 4'(k);
      end
    end
    return r;
  endfunction

  // Expected check digit (10 - s mod 10) mod 10; s*205 >> 11 is s/10 for s < 1029
  function automatic logic [3:0] check_of(input logic [7:0] s);
    logic [15:0] prod;
    logic [7:0]  rem;
    logic [3:0]  r;
    prod = 16'(s) * 16'd205;
    rem  = s - 8'(prod[15:11]) * 8'd10;
    r    = rem[3:0];
    return (r == 4'd0) ? 4'd0 : 4'd10 - r;
  endfunction

endpackage

>>> design/ean13_sym_stage.sv
// First pipeline stage: guard check and table lookup of all 24 symbols,
// forward and reversed reading. Depends on ean13_pkg.
`timescale 1ns / 1ps

module ean13_sym_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ean13_pkg::NumModules-1:0] in_mod,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ean13_pkg::sym_res_t           out_res
);

  ean13_pkg::sym_res_t res_next;

  always_comb begin
    logic [6:0]           p;
    ean13_pkg::left_hit_t lh;
    ean13_pkg::dig_hit_t  rh;
    int                   idx;
    res_next = '0;
    res_next.guards_ok = in_mod[0] && !in_mod[1] && in_mod[2] &&
                         !in_mod[45] && in_mod[46] && !in_mod[47] &&
                         in_mod[48] && !in_mod[49] &&
                         in_mod[92] && !in_mod[93] && in_mod[94];
    for (int d = 0; d < 2; d++) begin
      res_next.dir[d].ok = 1'b1;
      for (int i = 0; i < 6; i++) begin
        // left half symbol
        for (int t = 0; t < 7; t++) begin
          idx = 3 + 7 * i + t;
          p[6-t] = (d == 1) ? in_mod[94-idx] : in_mod[idx];
        end
        lh = ean13_pkg::decode_left(p);
        res_next.dir[d].dig[i] = lh.dig;
        res_next.dir[d].par[5-i] = lh.even;
        if (!lh.hit) res_next.dir[d].ok = 1'b0;
        // right half symbol
        for (int t = 0; t < 7; t++) begin
          idx = 50 + 7 * i + t;
          p[6-t] = (d == 1) ? in_mod[94-idx] : in_mod[idx];
        end
        rh = ean13_pkg::decode_right(p);
        res_next.dir[d].dig[6+i] = rh.dig;
        if (!rh.hit) res_next.dir[d].ok = 1'b0;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_res <= res_next;
    end
  end

endmodule

>>> design/ean13_sum_stage.sv
// Second pipeline stage: leading digit from the left parity pattern, BCD
// assembly and the weighted digit sum per direction. Depends on ean13_pkg.
`timescale 1ns / 1ps

module ean13_sum_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ean13_pkg::sym_res_t in_res,
  output logic                out_valid,
  input  logic                out_ready,
  output ean13_pkg::sum_res_t out_res
);

  ean13_pkg::sum_res_t res_next;

  always_comb begin
    ean13_pkg::dig_hit_t lead;
    logic [5:0]          s_one;
    logic [5:0]          s_three;
    res_next = '0;
    res_next.guards_ok = in_res.guards_ok;
    for (int d = 0; d < 2; d++) begin
      lead = ean13_pkg::decode_lead(in_res.dir[d].par);
      res_next.dir[d].ok = in_res.dir[d].ok && lead.hit;
      res_next.dir[d].bcd[51:48] = lead.dig;
      for (int i = 0; i < 12; i++) begin
        res_next.dir[d].bcd[47-4*i -: 4] = in_res.dir[d].dig[i];
      end
      // weight 1 on digits 0,2,..,10, weight 3 on digits 1,3,..,11
      s_one   = 6'(lead.dig);
      s_three = '0;
      for (int j = 0; j < 5; j++) begin
        s_one = s_one + 6'(in_res.dir[d].dig[2*j+1]);
      end
      for (int j = 0; j < 6; j++) begin
        s_three = s_three + 6'(in_res.dir[d].dig[2*j]);
      end
      res_next.dir[d].sum = 8'(s_one) + {1'b0, s_three, 1'b0} + 8'(s_three);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_res <= res_next;
    end
  end

endmodule

>>> design/ean13_check_stage.sv
// Final pipeline stage: check digit test, direction select and the output
// register driving the master stream. Depends on ean13_pkg.
`timescale 1ns / 1ps

module ean13_check_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ean13_pkg::sum_res_t in_res,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [55:0]         m_tdata,  // digits[51:0], zero pad
  output logic [2:0]          m_tuser   // decode_status[1:0], guards_ok
);

  logic                     fwd_ok;
  logic                     rev_ok;
  ean13_pkg::status_t       status_next;
  logic [ean13_pkg::DigitsW-1:0] digits_next;

  always_comb begin
    fwd_ok = in_res.dir[0].ok &&
             ean13_pkg::check_of(in_res.dir[0].sum) == in_res.dir[0].bcd[3:0];
    rev_ok = in_res.dir[1].ok &&
             ean13_pkg::check_of(in_res.dir[1].sum) == in_res.dir[1].bcd[3:0];
    priority if (fwd_ok) begin
      status_next = ean13_pkg::ST_FWD;
      digits_next = in_res.dir[0].bcd;
    end else if (rev_ok) begin
      status_next = ean13_pkg::ST_REV;
      digits_next = in_res.dir[1].bcd;
    end else begin
      status_next = ean13_pkg::ST_FAIL;
      digits_next = '0;
    end
  end

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_tdata <= {4'b0, digits_next};
      m_tuser <= {in_res.guards_ok, status_next};
    end
  end

endmodule

>>> design/ean13_symbol_decoder_unit.sv
// Top level of the EAN-13 symbol decoder: three-stage stream pipeline.
// Depends on ean13_pkg, ean13_sym_stage, ean13_sum_stage, ean13_check_stage.
`timescale 1ns / 1ps

// Decodes one quantized 95-module EAN-13 pattern per beat (bit k of s_tdata is
// module k, 1 = black) and returns one result beat per input beat, in order.
// Throughput is one pattern per clock while m_tready is high; each result passes
// through the three register stages (symbol lookup, digit sum, check
// and output register). Both reading directions are decoded in parallel; the
// forward reading wins when both pass. Each stage takes a new beat whenever it
// is empty or its result moves on, so s_tready follows m_tready combinationally
// only once the whole pipeline is full. On failure digits read as zero.

module ean13_symbol_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // modules_low[47:0], modules_high[46:0], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // digits[51:0], zero pad
  output logic [2:0]  m_tuser    // decode_status[1:0], guards_ok
);

  logic                s1_valid;
  logic                s1_ready;
  ean13_pkg::sym_res_t s1_res;
  logic                s2_valid;
  logic                s2_ready;
  ean13_pkg::sum_res_t s2_res;

  ean13_sym_stage u_sym (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mod    (s_tdata[ean13_pkg::NumModules-1:0]),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_res   (s1_res)
  );

  ean13_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_res    (s1_res),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_res   (s2_res)
  );

  ean13_check_stage u_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_ready (s2_ready),
    .in_res   (s2_res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // a failed decode carries no digits
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ean13_pkg::ST_FAIL |-> m_tdata == '0)
    else $error("failed decode with nonzero digits");

  // input back-pressure only when every stage is full and the sink stalls
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready && s1_valid && s2_valid)
    else $error("input stalled with room in the pipeline");

  // a successful decode always ends in a valid BCD check digit
  a_check_bcd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != ean13_pkg::ST_FAIL |-> m_tdata[3:0] <= 4'd9)
    else $error("check digit out of range");

endmodule
